@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/pgs_pkg.sv @@
// Package for the pinyin segmenter: token types and the syllable lookup.
// Depends on nothing.
`timescale 1ns / 1ps
package pgs_pkg;
    localparam int TokChars = 6;
    localparam logic [15:0] ChA = 16'd97;

    // Encoded syllable as six 5-bit letters (0 = unused, 1..26 = a..z).
    typedef logic [29:0] t_key;

    function automatic logic [4:0] ltr(input logic [15:0] c);
        logic [4:0] r;
        begin
            if (c >= 16'd97 && c <= 16'd122) r = 5'(c - ChA + 16'd1);
            else r = 5'd31;
            return r;
        end
    endfunction

    localparam string Dict = {
        " a ai an ang ao ",
        "ba bai ban bang bao bei ben beng bi bian biao bie bin bing bo bu ",
        "ca cai can cang cao ce cen ceng cha chai chan chang chao che chen cheng ",
        "chi chong chou chu chuai chuan chuang chui chun chuo ci cong cou cu cuan ",
        "cui cun cuo ",
        "da dai dan dang dao de dei den deng di dian diao die ding diu dong dou du ",
        "duan dui dun duo ",
        "e ei en eng er ",
        "fa fan fang fei fen feng fo fou fu ",
        "ga gai gan gang gao ge gei gen geng gong gou gu gua guai guan guang gui ",
        "gun guo ",
        "ha hai han hang hao he hei hen heng hong hou hu hua huai huan huang hui ",
        "hun huo ",
        "ji jia jian jiang jiao jie jin jing jiong jiu ju juan jue jun ",
        "ka kai kan kang kao ke kei ken keng kong kou ku kua kuai kuan kuang kui ",
        "kun kuo ",
        "la lai lan lang lao le lei leng li lia lian liang liao lie lin ling liu ",
        "long lou lu luan lue lun luo lv ",
        "ma mai man mang mao me mei men meng mi mian miao mie min ming miu mo mou ",
        "mu ",
        "na nai nan nang nao ne nei nen neng ni nian niang niao nie nin ning niu ",
        "nong nou nu nuan nue nuo nv ",
        "o ou ",
        "pa pai pan pang pao pei pen peng pi pian piao pie pin ping po pou pu ",
        "qi qia qian qiang qiao qie qin qing qiong qiu qu quan que qun ",
        "ran rang rao re ren reng ri rong rou ru ruan rui run ruo ",
        "sa sai san sang sao se sen seng sha shai shan shang shao she shei shen ",
        "sheng shi shou shu shua shuai shuan shuang shui shun shuo si song sou su ",
        "suan sui sun suo ",
        "ta tai tan tang tao te tei teng ti tian tiao tie ting tong tou tu tuan ",
        "tui tun tuo ",
        "wa wai wan wang wei wen weng wo wu ",
        "xi xia xian xiang xiao xie xin xing xiong xiu xu xuan xue xun ",
        "ya yan yang yao ye yi yin ying yo yong you yu yuan yue yun ",
        "za zai zan zang zao ze zei zen zeng zha zhai zhan zhang zhao zhe zhei ",
        "zhen zheng zhi zhong zhou zhu zhua zhuai zhuan zhuang zhui zhun zhuo zi ",
        "zong zou zu zuan zui zun zuo "
    };

    // Lookup: scans the constant list; letters past the entry's end must be zero in the key.
    function automatic logic in_dict(input t_key k);
        logic hit;
        int   p;
        int   j;
        logic same;
        logic ended;
        begin
            hit = 1'b0;
            for (p = 0; p < Dict.len() - 1; p++) begin
                if (Dict[p] == " " && Dict[p+1] != " ") begin
                    same  = 1'b1;
                    ended = 1'b0;
                    for (j = 0; j < TokChars; j++) begin
                        if (!ended && p + 1 + j < Dict.len() && Dict[p+1+j] != " ") begin
                            if (k[5*j +: 5] != 5'(Dict[p+1+j] - 8'd96)) same = 1'b0;
                        end else begin
                            ended = 1'b1;
                            if (k[5*j +: 5] != 5'd0) same = 1'b0;
                        end
                    end
                    if (same) hit = 1'b1;
                end
            end
            return hit;
        end
    endfunction

    typedef struct packed {
        logic [2:0]  len;
        logic [15:0] c0, c1, c2, c3, c4, c5;
        logic        last;
    } t_tok;
endpackage

@@ rtl/pgs_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module pgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/pinyin_greedy_segmenter.sv @@
// Pinyin greedy longest-match segmenter.
// Each request is written to the pending RAM; when it completes a token, six chars are
// pulled from the pending RAM, then 1 to 6 dictionary probes pick the token to present.
// The input is taken only while idle: a request without a token frees it after its
// write; one that emits a token holds it until every flushed token has been taken.
// Reset: synchronous active low; clears count and control, RAM is not cleared.
`timescale 1ns / 1ps
module pinyin_greedy_segmenter #(
    parameter int MAX_SYLLABLE_LEN = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [103:0] m_axis_tdata,  // token_length[2:0], char_0..char_5, pad
    output logic        m_axis_tlast    // last_token
);
    import pgs_pkg::*;
    `include "assert_macros.svh"

    localparam int Win = (MAX_SYLLABLE_LEN < TokChars) ? MAX_SYLLABLE_LEN : TokChars;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_WR = 6'b000010, S_RD = 6'b000100,
        S_PROBE = 6'b001000, S_OUT = 6'b010000, S_SHIFT = 6'b100000
    } t_state;

    t_state      r_state;
    logic [2:0]  r_cnt;
    logic [2:0]  r_base;     // circular head index in RAM
    logic [2:0]  r_idx;
    logic        r_last;
    logic [15:0] r_c [TokChars];
    logic [15:0] r_in;
    logic [2:0]  r_len;
    logic [2:0]  r_pl;       // prefix length under probe
    t_tok        r_tok;

    logic        we;
    logic [2:0]  waddr, raddr;
    logic [15:0] rdata;

    pgs_ram #(.WIDTH(16), .DEPTH(8)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(r_in),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [2:0] wrap(input logic [3:0] a);
        return (a >= 4'd6) ? 3'(a - 4'd6) : a[2:0];
    endfunction

    // tail position: overflow overwrites slot 5
    logic [2:0] wcnt;
    assign wcnt  = (r_cnt == 3'd6) ? 3'd5 : r_cnt;
    assign we    = (r_state == S_WR);
    assign waddr = wrap(4'(r_base) + 4'(wcnt));
    assign raddr = wrap(4'(r_base) + 4'(r_idx));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_tok.c5, r_tok.c4, r_tok.c3, r_tok.c2, r_tok.c1,
                            r_tok.c0, r_tok.len};
    assign m_axis_tlast  = r_tok.last;

    // one dictionary probe per cycle, longest prefix first
    t_key key;
    logic hit;
    always_comb begin
        key = '0;
        for (int j = 0; j < TokChars; j++)
            if (3'(j) < r_pl) key[5*j +: 5] = ltr(r_c[j]);
        hit = in_dict(key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_base  <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_in    <= s_axis_tdata;
                    r_last  <= s_axis_tlast;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_cnt <= (r_cnt == 3'd6) ? 3'd6 : 3'(r_cnt + 3'd1);
                    r_idx <= '0;
                    if (r_last || r_cnt >= 3'd5) r_state <= S_RD;
                    else r_state <= S_IDLE;
                end
                S_RD: begin
                    // read pipeline: data for index idx-1 arrives now
                    if (r_idx != 3'd0) r_c[r_idx - 3'd1] <= rdata;
                    if (r_idx == 3'd6) begin
                        r_pl    <= (r_cnt < 3'(Win)) ? r_cnt : 3'(Win);
                        r_state <= S_PROBE;
                    end else r_idx <= 3'(r_idx + 3'd1);
                end
                S_PROBE: begin
                    // a single char goes out even without a match
                    if (hit || r_pl == 3'd1) begin
                        r_len <= r_pl;
                        r_tok.len <= r_pl;
                        r_tok.c0 <= r_c[0];
                        r_tok.c1 <= (r_pl > 3'd1) ? r_c[1] : 16'd0;
                        r_tok.c2 <= (r_pl > 3'd2) ? r_c[2] : 16'd0;
                        r_tok.c3 <= (r_pl > 3'd3) ? r_c[3] : 16'd0;
                        r_tok.c4 <= (r_pl > 3'd4) ? r_c[4] : 16'd0;
                        r_tok.c5 <= (r_pl > 3'd5) ? r_c[5] : 16'd0;
                        r_tok.last <= r_last && (r_cnt == r_pl);
                        r_state <= S_OUT;
                    end else r_pl <= 3'(r_pl - 3'd1);
                end
                S_OUT: if (m_axis_tready) r_state <= S_SHIFT;
                S_SHIFT: begin
                    r_cnt  <= 3'(r_cnt - r_len);
                    r_base <= wrap(4'(r_base) + 4'(r_len));
                    r_idx  <= '0;
                    if (r_last && r_cnt != r_len) r_state <= S_RD;
                    else r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd6)
    `ASSERT_IMPL(a_len_ok, i_clk, i_rst_n, m_axis_tvalid, r_tok.len >= 3'd1 && r_tok.len <= r_cnt)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

@@ tb/tb_top.sv @@
// Testbench for pinyin_greedy_segmenter: streams strings, predicts tokens by greedy
// longest match against its own syllable list, and compares every token field by field.
// Depends on the RTL top module only.
`timescale 1ns / 1ps
module tb_top;
    localparam int TokMax = 6;
    localparam int LimitCycles = 400000;

    localparam string Syllables = {
        " a ai an ang ao ",
        "ba bai ban bang bao bei ben beng bi bian biao bie bin bing bo bu ",
        "ca cai can cang cao ce cen ceng cha chai chan chang chao che chen cheng ",
        "chi chong chou chu chuai chuan chuang chui chun chuo ci cong cou cu cuan ",
        "cui cun cuo ",
        "da dai dan dang dao de dei den deng di dian diao die ding diu dong dou du ",
        "duan dui dun duo ",
        "e ei en eng er ",
        "fa fan fang fei fen feng fo fou fu ",
        "ga gai gan gang gao ge gei gen geng gong gou gu gua guai guan guang gui ",
        "gun guo ",
        "ha hai han hang hao he hei hen heng hong hou hu hua huai huan huang hui ",
        "hun huo ",
        "ji jia jian jiang jiao jie jin jing jiong jiu ju juan jue jun ",
        "ka kai kan kang kao ke kei ken keng kong kou ku kua kuai kuan kuang kui ",
        "kun kuo ",
        "la lai lan lang lao le lei leng li lia lian liang liao lie lin ling liu ",
        "long lou lu luan lue lun luo lv ",
        "ma mai man mang mao me mei men meng mi mian miao mie min ming miu mo mou ",
        "mu ",
        "na nai nan nang nao ne nei nen neng ni nian niang niao nie nin ning niu ",
        "nong nou nu nuan nue nuo nv ",
        "o ou ",
        "pa pai pan pang pao pei pen peng pi pian piao pie pin ping po pou pu ",
        "qi qia qian qiang qiao qie qin qing qiong qiu qu quan que qun ",
        "ran rang rao re ren reng ri rong rou ru ruan rui run ruo ",
        "sa sai san sang sao se sen seng sha shai shan shang shao she shei shen ",
        "sheng shi shou shu shua shuai shuan shuang shui shun shuo si song sou su ",
        "suan sui sun suo ",
        "ta tai tan tang tao te tei teng ti tian tiao tie ting tong tou tu tuan ",
        "tui tun tuo ",
        "wa wai wan wang wei wen weng wo wu ",
        "xi xia xian xiang xiao xie xin xing xiong xiu xu xuan xue xun ",
        "ya yan yang yao ye yi yin ying yo yong you yu yuan yue yun ",
        "za zai zan zang zao ze zei zen zeng zha zhai zhan zhang zhao zhe zhei ",
        "zhen zheng zhi zhong zhou zhu zhua zhuai zhuan zhuang zhui zhun zhuo zi ",
        "zong zou zu zuan zui zun zuo "
    };

    typedef struct packed {
        logic [2:0]  len;
        logic [15:0] c0, c1, c2, c3, c4, c5;
        logic        last;
    } t_token;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;   // char_code
    logic         s_axis_tlast;   // last_char
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // token_length[2:0], char_0..char_5, pad
    logic         m_axis_tlast;   // last_token

    pinyin_greedy_segmenter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    logic [15:0] held_chars[TokMax];
    int          held_count;
    t_token      token_queue[$];
    int          err_count;
    int          cycle_count;
    int          burst_left;
    string       syl_list[$];

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_syllable(input logic [15:0] s[TokMax], input int n);
        int k;
        bit same;
        foreach (syl_list[i]) begin
            if (syl_list[i].len() == n) begin
                same = 1'b1;
                for (k = 0; k < n; k++)
                    if (s[k] != 16'(syl_list[i][k])) same = 1'b0;
                if (same) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void cut_token(input bit final_str);
        t_token t;
        int n;
        int l;
        int j;
        n = 1;
        for (l = held_count; l > 0; l--)
            if (is_syllable(held_chars, l)) begin
                n = l;
                break;
            end
        t.len = 3'(n);
        t.c0 = held_chars[0];
        t.c1 = n > 1 ? held_chars[1] : 16'd0;
        t.c2 = n > 2 ? held_chars[2] : 16'd0;
        t.c3 = n > 3 ? held_chars[3] : 16'd0;
        t.c4 = n > 4 ? held_chars[4] : 16'd0;
        t.c5 = n > 5 ? held_chars[5] : 16'd0;
        for (j = 0; j < TokMax; j++)
            held_chars[j] = (j + n < held_count) ? held_chars[j + n] : 16'd0;
        held_count -= n;
        t.last = final_str && held_count == 0;
        token_queue = {token_queue, t};
    endfunction

    function automatic void predict_char(input logic [15:0] c, input bit last);
        if (held_count >= TokMax) held_count = TokMax - 1;
        held_chars[held_count] = c;
        held_count++;
        if (last) begin
            while (held_count > 0) cut_token(1'b1);
        end else if (held_count == TokMax) begin
            cut_token(1'b0);
        end
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // sender: bursts with random gaps; request held until accepted
    task automatic send_char(input logic [15:0] c, input bit last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_char(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_word(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send_char(16'(s[i]), last && i == s.len() - 1);
    endtask

    // receiver stalls at random outside a periodic window in which it never stalls
    always @(negedge i_clk) begin
        if (cycle_count % 500 < 150) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LimitCycles) begin
            $display("[pinyin_greedy_segmenter] ERROR");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.len = m_axis_tdata[2:0];
            got.c0 = m_axis_tdata[18:3];
            got.c1 = m_axis_tdata[34:19];
            got.c2 = m_axis_tdata[50:35];
            got.c3 = m_axis_tdata[66:51];
            got.c4 = m_axis_tdata[82:67];
            got.c5 = m_axis_tdata[98:83];
            got.last = m_axis_tlast;
            if (token_queue.size() == 0) begin
                report("unexpected token", m_axis_tdata[18:3], 16'd0);
            end else begin
                want = token_queue.pop_front();
                if (got.len != want.len)
                    report("token_length", 16'(got.len), 16'(want.len));
                if (got.c0 != want.c0) report("char_0", got.c0, want.c0);
                if (got.c1 != want.c1) report("char_1", got.c1, want.c1);
                if (got.c2 != want.c2) report("char_2", got.c2, want.c2);
                if (got.c3 != want.c3) report("char_3", got.c3, want.c3);
                if (got.c4 != want.c4) report("char_4", got.c4, want.c4);
                if (got.c5 != want.c5) report("char_5", got.c5, want.c5);
                if (got.last != want.last)
                    report("last_token", 16'(got.last), 16'(want.last));
            end
        end
    end

    function automatic logic [15:0] rand_char();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(65, 90));      // uppercase never matches
            1: return 16'($urandom);
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(97, 122));
        endcase
    endfunction

    task automatic test_directed();
        send_word("chuang", 1'b1);          // six-letter entry
        send_word("xian", 1'b1);            // longest match beats xi+an
        send_word("nvlv", 1'b1);
        send_word("zhuangzhuang", 1'b0);    // window full mid-string
        send_word("a", 1'b1);
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h5555, 1'b0);
        send_char(16'hAAAA, 1'b1);
        send_word("ABC", 1'b1);             // uppercase emitted alone
        send_word("q", 1'b1);               // single non-syllable letter
    endtask

    task automatic test_syllables();
        string s;
        for (int n = 0; n < 55; n++) begin
            s = syl_list[$urandom_range(0, syl_list.size() - 1)];
            if ($urandom_range(0, 4) == 0) s = {s, string'(8'($urandom_range(97, 122)))};
            send_word(s, $urandom_range(0, 3) == 0);
        end
        send_word("a", 1'b1);
    endtask

    task automatic test_noise();
        for (int n = 0; n < 150; n++)
            send_char(rand_char(), $urandom_range(0, 6) == 0);
        send_char(rand_char(), 1'b1);
    endtask

    initial begin
        syl_list = {};
        begin
            string w;
            w = "";
            for (int i = 0; i < Syllables.len(); i++) begin
                if (Syllables[i] == " ") begin
                    if (w.len() > 0) syl_list = {syl_list, w};
                    w = "";
                end else begin
                    w = {w, string'(Syllables[i])};
                end
            end
        end
        held_count = 0;
        err_count = 0;
        cycle_count = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 16'd0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_syllables();
        test_noise();
        s_axis_tvalid <= 1'b0;
        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && token_queue.size() == 0)
            $display("[pinyin_greedy_segmenter] OK");
        else
            $display("[pinyin_greedy_segmenter] ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/pgs_pkg.sv
rtl/pgs_ram.sv
rtl/pinyin_greedy_segmenter.sv
tb/tb_top.sv
